FILE: sv/kcm_pkg.sv
// ============================================================================
// kcm_pkg
// Shared types and constants for the key-chord match table: table sizes,
// field widths, item kinds, controller states and the control/status
// bundles passed between controller and datapath.
// ============================================================================
package kcm_pkg;

    // Table and field sizes
    localparam int SLOTS       = 128;
    localparam int KEY_BITS    = 16;
    localparam int TAG_BITS    = 32;
    localparam int MODS_BITS   = 8;
    localparam int HANDLE_BITS = 31;
    localparam int KIND_BITS   = 2;
    localparam int IDX_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Stream packing: slave tuser = {is_key_down, kind}
    localparam int IN_USER_BITS  = KIND_BITS + 1;
    localparam int IN_RAW_BITS   = KEY_BITS + MODS_BITS + HANDLE_BITS + TAG_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 1 + HANDLE_BITS + 1 + TAG_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [HANDLE_BITS-1:0] HANDLE_MAX   = {HANDLE_BITS{1'b1}};
    localparam logic [HANDLE_BITS-1:0] HANDLE_FIRST = HANDLE_BITS'(1);
    localparam logic [IDX_BITS-1:0]    IDX_LAST     = IDX_BITS'(SLOTS - 1);

    // Item kinds (code 3 is unused and ignored)
    typedef enum logic [KIND_BITS-1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_UNREGISTER = 2'd1,
        KIND_KEY_EVENT  = 2'd2
    } kind_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item, restart the scan
        logic scan;      // step the slot scan one entry
        logic commit;    // apply the table update and load the result
    } kcm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_scan;  // incoming item has to search the table
        logic match;       // compared slot satisfies the search
        logic last;        // compared slot is the final one
        logic out_free;    // result register can take a new result
    } kcm_stat_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [MODS_BITS-1:0]   mods;
        logic [HANDLE_BITS-1:0] handle;
        logic [TAG_BITS-1:0]    tag;
    } entry_t;

endpackage

FILE: sv/key_chord_match_table_unit.sv
// ============================================================================
// key_chord_match_table_unit
// Key-chord binding table: register, unregister and key-event lookup.
//
// Usage:
//   Slave stream carries one item per transfer; tuser selects the kind
//   (register, unregister, key event) and flags key-down. Every item gives
//   exactly one result transfer on the master stream.
//   Items that search the table walk the slots in order through a memory
//   with a registered read port, one slot per cycle, stopping at the first
//   hit; the result is then loaded at commit. Non-key-down events and the
//   unused kind skip the scan and go straight to commit.
//   One item is in work at a time: the next item is taken the cycle after
//   the previous result is loaded, so a finished result may wait while the
//   next is scanned.
//   When the receiver stalls, the result is held and a newly finished item
//   waits in the commit step until the result register frees.
//   Reset clears all slot valid bits and sets the handle counter to 1;
//   no clearing pass is needed.
// ============================================================================
module key_chord_match_table_unit
    import kcm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // slave stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // key, modifier_mask, handle, action_tag
    input  logic [IN_USER_BITS-1:0]  s_tuser,   // kind, is_key_down
    // master stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata    // status, assigned_handle, handled, matched_tag
);

    kcm_cmd_t  cmd;
    kcm_stat_t stat;

    // Controller
    kcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    kcm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

FILE: sv/kcm_ctrl.sv
// ============================================================================
// kcm_ctrl
// Controller for the key-chord match table. Takes one item at a time,
// runs the slot scan when the item needs one and commits the result once
// the result register is free.
// ============================================================================
module kcm_ctrl
    import kcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  kcm_stat_t stat,
    output kcm_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.needs_scan ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (stat.match || stat.last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/kcm_datapath.sv
// ============================================================================
// kcm_datapath
// Datapath of the key-chord match table: item latch, slot memory with
// registered read, per-slot valid bits, handle counter, scan compare and
// the result register on the master stream.
// ============================================================================
module kcm_datapath
    import kcm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic [IN_USER_BITS-1:0]  s_tuser,
    input  kcm_cmd_t                 cmd,
    output kcm_stat_t                stat,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready
);

    // Incoming fields
    logic [KIND_BITS-1:0]   in_kind;
    logic                   in_down;
    logic [KEY_BITS-1:0]    in_key;
    logic [MODS_BITS-1:0]   in_mods;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [TAG_BITS-1:0]    in_tag;

    assign in_kind   = s_tuser[KIND_BITS-1:0];
    assign in_down   = s_tuser[KIND_BITS];
    assign in_key    = s_tdata[KEY_BITS-1:0];
    assign in_mods   = s_tdata[KEY_BITS +: MODS_BITS];
    assign in_handle = s_tdata[KEY_BITS+MODS_BITS +: HANDLE_BITS];
    assign in_tag    = s_tdata[KEY_BITS+MODS_BITS+HANDLE_BITS +: TAG_BITS];

    // Latched item
    logic [KIND_BITS-1:0]   kind_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [MODS_BITS-1:0]   mods_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [TAG_BITS-1:0]    tag_reg;

    // Table state
    logic [SLOTS-1:0]       valid_reg;
    logic [HANDLE_BITS-1:0] counter_reg;
    entry_t                 mem [SLOTS];
    entry_t                 rd_entry_reg;
    entry_t                 wr_entry;
    logic                   mem_we;

    // Scan state
    logic                   needs_scan;
    logic [IDX_BITS-1:0]    scan_idx_reg;
    logic [IDX_BITS-1:0]    cmp_idx_reg;
    logic                   cmp_valid_reg;
    logic                   found_reg;
    logic [IDX_BITS-1:0]    found_idx_reg;
    logic [TAG_BITS-1:0]    found_tag_reg;
    logic                   hit;

    // Result register
    logic                   out_valid_reg;
    logic                   out_status_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic                   out_handled_reg;
    logic [TAG_BITS-1:0]    out_tag_reg;
    logic [OUT_RAW_BITS-1:0] out_raw;

    // Does the incoming item search the table
    always_comb
    begin
        case (in_kind)
            KIND_REGISTER:   needs_scan = 1'b1;
            KIND_UNREGISTER: needs_scan = 1'b1;
            KIND_KEY_EVENT:  needs_scan = in_down;
            default:         needs_scan = 1'b0;
        endcase
    end

    assign stat.needs_scan = needs_scan;

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            key_reg    <= in_key;
            mods_reg   <= in_mods;
            handle_reg <= in_handle;
            tag_reg    <= in_tag;
        end
    end

    // Compare the slot read in the previous cycle
    always_comb
    begin
        case (kind_reg)
            KIND_REGISTER:   hit = !valid_reg[cmp_idx_reg];
            KIND_UNREGISTER: hit = valid_reg[cmp_idx_reg] &&
                                   (rd_entry_reg.handle == handle_reg);
            KIND_KEY_EVENT:  hit = valid_reg[cmp_idx_reg] &&
                                   (rd_entry_reg.key == key_reg) &&
                                   (rd_entry_reg.mods == mods_reg);
            default:         hit = 1'b0;
        endcase
    end

    assign stat.match    = cmp_valid_reg && hit;
    assign stat.last     = cmp_valid_reg && (cmp_idx_reg == IDX_LAST);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Scan index, compare stage and first match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (cmd.capture)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
                cmp_idx_reg  <= scan_idx_reg;
                if (stat.match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Matched slot payload
    always_ff @(posedge clk)
    begin
        if (cmd.scan && stat.match)
        begin
            found_idx_reg <= cmp_idx_reg;
            found_tag_reg <= rd_entry_reg.tag;
        end
    end

    // Slot memory: one write port at commit, one registered read for the scan
    assign mem_we          = cmd.commit && found_reg && (kind_reg == KIND_REGISTER);
    assign wr_entry.key    = key_reg;
    assign wr_entry.mods   = mods_reg;
    assign wr_entry.handle = counter_reg;
    assign wr_entry.tag    = tag_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[found_idx_reg] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_idx_reg];
    end

    // Valid bits and handle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            counter_reg <= HANDLE_FIRST;
        end
        else if (cmd.commit && found_reg)
        begin
            case (kind_reg)
                KIND_REGISTER:
                begin
                    valid_reg[found_idx_reg] <= 1'b1;
                    counter_reg <= (counter_reg == HANDLE_MAX) ? HANDLE_FIRST
                                                               : counter_reg + HANDLE_BITS'(1);
                end
                KIND_UNREGISTER:
                begin
                    valid_reg[found_idx_reg] <= 1'b0;
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg  <= 1'b0;
            out_handle_reg  <= '0;
            out_handled_reg <= 1'b0;
            out_tag_reg     <= '0;
            case (kind_reg)
                KIND_REGISTER:
                begin
                    out_status_reg <= !found_reg;
                    out_handle_reg <= found_reg ? counter_reg : '0;
                end
                KIND_KEY_EVENT:
                begin
                    out_handled_reg <= found_reg;
                    out_tag_reg     <= found_reg ? found_tag_reg : '0;
                end
                default:
                begin
                    out_status_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_raw  = {out_tag_reg, out_handled_reg, out_handle_reg, out_status_reg};
    assign m_tdata  = OUT_DATA_BITS'(out_raw);
    assign m_tvalid = out_valid_reg;

    // Handle counter never holds the reserved value zero
    a_counter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != '0)
        else $error("handle counter reached zero");

    // A full-table result carries no handle and no match
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> (out_handle_reg == '0 && !out_handled_reg))
        else $error("full status with nonzero result fields");

    // Slot occupancy changes only on a commit
    a_valid_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.commit) |-> $stable(valid_reg))
        else $error("valid bits changed outside commit");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench for key_chord_match_table_unit. A directed sequence covers field
// extremes, every item kind, duplicate chords, mismatches on key or
// modifiers, non-key-down events, unknown handles and the unused kind. A long
// random run then fills and drains the table repeatedly, reaching the full
// condition. A scoreboard class tracks the binding table and checks every
// result transfer in order. Stalls on both sides vary by phase, then stop.
// ============================================================================
module tb_top;
    import kcm_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam logic [KEY_BITS-1:0]  KEY_POOL_BASE = 16'h0040;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = SLOTS + 12;

    // One input item, unpacked
    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [KEY_BITS-1:0]    key;
        logic [MODS_BITS-1:0]   mods;
        logic                   down;
        logic [HANDLE_BITS-1:0] handle;
        logic [TAG_BITS-1:0]    tag;
    } chord_item_t;

    // One result, unpacked
    typedef struct packed {
        logic                   status;
        logic [HANDLE_BITS-1:0] handle;
        logic                   handled;
        logic [TAG_BITS-1:0]    tag;
    } chord_result_t;

    // ------------------------------------------------------------------------
    // Binding table tracker: mirrors the table and holds expected results
    // ------------------------------------------------------------------------
    class chord_table_tracker;
        bit                     bound[SLOTS];
        logic [KEY_BITS-1:0]    bound_key[SLOTS];
        logic [MODS_BITS-1:0]   bound_mods[SLOTS];
        logic [HANDLE_BITS-1:0] bound_handle[SLOTS];
        logic [TAG_BITS-1:0]    bound_tag[SLOTS];
        logic [HANDLE_BITS-1:0] next_handle;
        chord_result_t          pending_results[$];
        int                     mismatch_count;

        function new();
            foreach (bound[i]) bound[i] = 1'b0;
            next_handle    = HANDLE_FIRST;
            mismatch_count = 0;
        endfunction

        // Apply one accepted item and queue the result it must produce
        function void note_item(chord_item_t it);
            chord_result_t r;
            r = '0;
            case (it.kind)
                KIND_REGISTER:
                begin
                    r.status = 1'b1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!bound[i])
                        begin
                            bound[i]        = 1'b1;
                            bound_key[i]    = it.key;
                            bound_mods[i]   = it.mods;
                            bound_handle[i] = next_handle;
                            bound_tag[i]    = it.tag;
                            r.status        = 1'b0;
                            r.handle        = next_handle;
                            next_handle     = (next_handle == HANDLE_MAX) ?
                                              HANDLE_FIRST : next_handle + HANDLE_BITS'(1);
                            break;
                        end
                    end
                end
                KIND_UNREGISTER:
                begin
                    // unknown handles are accepted silently
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (bound[i] && bound_handle[i] == it.handle)
                        begin
                            bound[i] = 1'b0;
                            break;
                        end
                    end
                end
                KIND_KEY_EVENT:
                begin
                    if (it.down)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (bound[i] && bound_key[i] == it.key &&
                                bound_mods[i] == it.mods)
                            begin
                                r.handled = 1'b1;
                                r.tag     = bound_tag[i];
                                break;
                            end
                        end
                    end
                end
                default: ;  // unused kind: all zero
            endcase
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [OUT_DATA_BITS-1:0] d);
            chord_result_t got;
            chord_result_t want;
            got.status  = d[0];
            got.handle  = d[1 +: HANDLE_BITS];
            got.handled = d[HANDLE_BITS + 1];
            got.tag     = d[HANDLE_BITS + 2 +: TAG_BITS];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status=%0d handle=%0d handled=%0d tag=%h",
                         $time, got.status, got.handle, got.handled, got.tag);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch: expected status=%0d handle=%0d handled=%0d tag=%h",
                         $time, want.status, want.handle, want.handled, want.tag);
                $display("%0t:           actual   status=%0d handle=%0d handled=%0d tag=%h",
                         $time, got.status, got.handle, got.handled, got.tag);
                mismatch_count++;
            end
        endfunction

        // Random bound slot, or -1 when the table is empty
        function int pick_bound_slot();
            int idx[$];
            foreach (bound[i]) if (bound[i]) idx.push_back(i);
            if (idx.size() == 0) return -1;
            return idx[$urandom_range(idx.size() - 1)];
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // key, modifier_mask, handle, action_tag
    logic [IN_USER_BITS-1:0]  s_tuser  = '0;   // kind, is_key_down
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // status, assigned_handle, handled, matched_tag

    int unsigned s_idle_pct = 15;
    int unsigned m_idle_pct = 80;
    int          cycle_count = 0;

    chord_table_tracker tracker = new();

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    key_chord_match_table_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic chord_item_t make_item(logic [KIND_BITS-1:0] kind,
                                              logic [KEY_BITS-1:0] key,
                                              logic [MODS_BITS-1:0] mods,
                                              logic down,
                                              logic [HANDLE_BITS-1:0] handle,
                                              logic [TAG_BITS-1:0] tag);
        chord_item_t it;
        it.kind   = kind;
        it.key    = key;
        it.mods   = mods;
        it.down   = down;
        it.handle = handle;
        it.tag    = tag;
        return it;
    endfunction

    // Random item; filling biases toward registers, otherwise toward removal
    function automatic chord_item_t random_item(bit filling);
        chord_item_t it;
        int          roll;
        int          slot;
        int          reg_w;
        int          unreg_w;
        it.key    = KEY_BITS'($urandom);
        it.mods   = MODS_BITS'($urandom);
        it.down   = 1'($urandom);
        it.handle = HANDLE_BITS'($urandom);
        it.tag    = TAG_BITS'($urandom);
        reg_w     = filling ? 55 : 15;
        unreg_w   = filling ? 10 : 45;
        roll      = $urandom_range(99);
        if (roll < reg_w)
        begin
            it.kind = KIND_REGISTER;
            // mostly a small chord pool so duplicates and hits are common
            if ($urandom_range(3) != 0)
            begin
                it.key  = KEY_POOL_BASE + KEY_BITS'($urandom_range(7));
                it.mods = MODS_BITS'($urandom_range(3));
            end
        end
        else if (roll < reg_w + unreg_w)
        begin
            it.kind = KIND_UNREGISTER;
            slot    = tracker.pick_bound_slot();
            if (slot >= 0 && $urandom_range(4) != 0)
                it.handle = tracker.bound_handle[slot];
            else if ($urandom_range(1) == 0)
                it.handle = tracker.next_handle - HANDLE_BITS'($urandom_range(1, 40));
        end
        else if (roll < reg_w + unreg_w + 30)
        begin
            it.kind = KIND_KEY_EVENT;
            it.down = ($urandom_range(9) != 0);
            slot    = tracker.pick_bound_slot();
            roll    = $urandom_range(3);
            if (slot >= 0 && roll < 2)
            begin
                it.key  = tracker.bound_key[slot];
                it.mods = tracker.bound_mods[slot];
            end
            else if (roll == 2)
            begin
                it.key  = KEY_POOL_BASE + KEY_BITS'($urandom_range(7));
                it.mods = MODS_BITS'($urandom_range(3));
            end
        end
        else
        begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // Drive one item; entered and left at a falling edge
    task automatic send_item(chord_item_t it);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'({it.tag, it.handle, it.mods, it.key});
        s_tuser  <= {it.down, it.kind};
        do @(posedge clk); while (!s_tready);
        tracker.note_item(it);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check each transfer
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= m_idle_pct);
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        chord_item_t directed[$];
        bit          filling;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, duplicates, mismatches, odd kinds
        directed.push_back(make_item(KIND_KEY_EVENT, '0, '0, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_REGISTER, '0, '0, 1'b0, '0, '0));
        directed.push_back(make_item(KIND_REGISTER, '1, '1, 1'b1, '1, '1));
        directed.push_back(make_item(KIND_REGISTER, 16'h1234, 8'h05, 1'b0, '0, 32'hA5A5_5A5A));
        directed.push_back(make_item(KIND_REGISTER, 16'h1234, 8'h05, 1'b0, '0, 32'h0000_1111));
        directed.push_back(make_item(KIND_KEY_EVENT, '1, '1, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, '0, '0, 1'b1, '1, '1));
        directed.push_back(make_item(KIND_KEY_EVENT, 16'h1234, 8'h05, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, '1, '1, 1'b0, '0, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, '1, 8'hFE, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, 16'hFFFE, '1, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_UNREGISTER, '0, '0, 1'b0, 31'd3, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, 16'h1234, 8'h05, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_UNREGISTER, '1, '1, 1'b1, HANDLE_MAX, '1));
        directed.push_back(make_item(KIND_UNREGISTER, '0, '0, 1'b0, '0, '0));
        directed.push_back(make_item(KIND_REGISTER, 16'h00FF, 8'h80, 1'b1, '1, 32'h8000_0001));
        directed.push_back(make_item(KIND_UNUSED, '1, '1, 1'b1, '1, '1));
        directed.push_back(make_item(KIND_UNUSED, '0, '0, 1'b0, '0, '0));
        directed.push_back(make_item(KIND_UNREGISTER, '0, '0, 1'b0, 31'd1, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, '0, '0, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_KEY_EVENT, 16'h00FF, 8'h80, 1'b1, '0, '0));
        directed.push_back(make_item(KIND_UNREGISTER, '0, '0, 1'b0, 31'd5, '0));
        directed.push_back(make_item(KIND_UNREGISTER, '0, '0, 1'b0, 31'd5, '0));
        directed.push_back(make_item(KIND_REGISTER, 16'h00FF, 8'h80, 1'b0, '0, 32'h7FFF_FFFE));
        foreach (directed[i]) send_item(directed[i]);

        // random: fill first, then alternate drain and fill bursts
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                s_idle_pct = 80;
                m_idle_pct = 15;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            filling = (n < 350) || (((n - 350) / 120) % 2 == 1);
            send_item(random_item(filling));
        end
        s_tvalid <= 1'b0;

        // wait for outstanding results, then watch for strays
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
